// ===== src/dfcw_pkg.sv =====
// ============================================================================
// dfcw_pkg
// Shared types, widths and coefficient tables for the decimating FIR with the
// optional CW band-pass stage.
// ============================================================================
package dfcw_pkg;

    localparam int TAP_COUNT = 32;
    localparam int TAP_W     = $clog2(TAP_COUNT);
    localparam int LINE_NUM  = 2;
    localparam int MEM_DEPTH = LINE_NUM * TAP_COUNT;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    localparam int ADC_W     = 10;
    localparam int SAMPLE_W  = 11;
    localparam int OUT_W     = 12;
    localparam int COEF_W    = 16;
    localparam int PROD_W    = SAMPLE_W + COEF_W;
    localparam int ACC_W     = 28;
    localparam int Q_SHIFT   = 15;

    localparam logic [SAMPLE_W-1:0] ADC_MID = 11'd512;

    // Delay line selector, used as the top address bit of the sample memory.
    localparam logic LINE_LP = 1'b0;
    localparam logic LINE_CW = 1'b1;

    localparam logic signed [COEF_W-1:0] LP_COEF [TAP_COUNT] = '{
        16'sd223,   16'sd361,   -16'sd138,  -16'sd550,
        -16'sd62,   16'sd714,   16'sd410,   -16'sd788,
        -16'sd931,  16'sd679,   16'sd1680,  -16'sd215,
        -16'sd2875, -16'sd1192, 16'sd6097,  16'sd13225,
        16'sd13225, 16'sd6097,  -16'sd1192, -16'sd2875,
        -16'sd215,  16'sd1680,  16'sd679,   -16'sd931,
        -16'sd788,  16'sd410,   16'sd714,   -16'sd62,
        -16'sd550,  -16'sd138,  16'sd361,   16'sd223
    };

    localparam logic signed [COEF_W-1:0] CW_COEF [TAP_COUNT] = '{
        -16'sd13,   -16'sd102,  -16'sd176,  -16'sd129,
        16'sd34,    16'sd148,   -16'sd38,   -16'sd686,
        -16'sd1703, -16'sd2693, -16'sd3097, -16'sd2460,
        -16'sd698,  16'sd1778,  16'sd4181,  16'sd5658,
        16'sd5658,  16'sd4181,  16'sd1778,  -16'sd698,
        -16'sd2460, -16'sd3097, -16'sd2693, -16'sd1703,
        -16'sd686,  -16'sd38,   16'sd148,   16'sd34,
        -16'sd129,  -16'sd176,  -16'sd102,  -16'sd13
    };

    typedef struct packed {
        logic                       we;
        logic [ADDR_W-1:0]          waddr;
        logic signed [SAMPLE_W-1:0] wdata;
        logic [ADDR_W-1:0]          raddr;
    } t_mem_req;

    typedef struct packed {
        logic             vld;
        logic             clr;
        logic             cw;
        logic [TAP_W-1:0] tap;
    } t_mac_ctl;

endpackage

// ===== src/dfcw_if.sv =====
// ============================================================================
// dfcw_if
// Valid/ready channel interfaces for converter samples and filtered results.
// ============================================================================
interface dfcw_in_if;
    logic                          valid;
    logic                          ready;
    logic [dfcw_pkg::ADC_W-1:0]    adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

interface dfcw_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [dfcw_pkg::OUT_W-1:0] filtered_sample;

    modport source (output valid, output filtered_sample, input ready);
    modport sink   (input valid, input filtered_sample, output ready);
endinterface

// ===== src/decimating_fir_with_cw_filter_unit.sv =====
// ============================================================================
// decimating_fir_with_cw_filter_unit
// Decimate-by-two 32-tap Q15 low-pass FIR with an optional cascaded 32-tap
// Q15 CW band-pass FIR, built around one sample memory and one MAC unit.
// ============================================================================
// Every input transfer stores one converter sample, less mid scale, into the
// low-pass delay line. A sample that produces no result leaves the block idle
// and ready for the next sample. Every second sample, starting with the first
// after reset, starts a low-pass convolution: the single read port of the
// sample memory delivers one tap per cycle into the shared multiply-accumulate
// unit, so one filter pass reads all 32 taps and then drains the pipeline.
// With cw_enable set, the low-pass value is written into the CW delay line and
// a second pass follows. A producing sample therefore holds the block through
// its filter passes and the output load, which waits for any earlier result;
// the next input is then taken even while the result still waits for its
// output transfer. The cw_enable register is written through i_cfg_we and
// i_cfg_wdata; the user must write it only while the block is idle, which the
// block itself does not enforce. Memory entries not written since reset read
// as zero, so no clearing pass is needed after reset.
module decimating_fir_with_cw_filter_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    dfcw_in_if.sink    i_in,
    dfcw_out_if.source o_out
);
    import dfcw_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_OUT
    } t_state;

    t_state                     r_state, n_state;
    logic                       r_phase, n_phase;
    logic [TAP_W-1:0]           r_in_idx, n_in_idx;
    logic [TAP_W-1:0]           r_cw_idx, n_cw_idx;
    logic [TAP_W-1:0]           r_newest, n_newest;
    logic [TAP_W-1:0]           r_tap, n_tap;
    logic                       r_line, n_line;
    logic [1:0]                 r_drain, n_drain;
    logic                       r_cw_en;
    t_mac_ctl                   r_mac_ctl, n_mac_ctl;
    logic                       r_out_valid, n_out_valid;
    logic signed [OUT_W-1:0]    r_out_data, n_out_data;

    t_mem_req                   w_mem_req;
    logic signed [SAMPLE_W-1:0] w_rdata;
    logic signed [ACC_W-1:0]    w_acc;
    logic                       w_in_xfer;
    logic                       w_out_xfer;

    localparam logic [1:0] DRAIN_LAST = 2'd2;

    assign w_in_xfer  = i_in.valid && i_in.ready;
    assign w_out_xfer = o_out.valid && o_out.ready;

    assign i_in.ready            = (r_state == S_IDLE);
    assign o_out.valid           = r_out_valid;
    assign o_out.filtered_sample = r_out_data;

    dfcw_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mem_req),
        .o_rdata (w_rdata)
    );

    dfcw_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (w_rdata),
        .i_ctl   (r_mac_ctl),
        .o_acc   (w_acc)
    );

    // Sequencer. The read address walks backward from the newest entry, so
    // tap k of the coefficient table meets sample x[n-k].
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_in_idx    = r_in_idx;
        n_cw_idx    = r_cw_idx;
        n_newest    = r_newest;
        n_tap       = r_tap;
        n_line      = r_line;
        n_drain     = r_drain;
        n_mac_ctl   = '0;
        n_out_valid = r_out_valid && !w_out_xfer;
        n_out_data  = r_out_data;

        w_mem_req.we    = 1'b0;
        w_mem_req.waddr = {LINE_LP, r_in_idx};
        w_mem_req.wdata = SAMPLE_W'(i_in.adc_sample) - ADC_MID;
        w_mem_req.raddr = {r_line, TAP_W'(r_newest - r_tap)};

        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    w_mem_req.we = 1'b1;
                    n_in_idx     = r_in_idx + 1'b1;
                    n_phase      = !r_phase;
                    if (!r_phase) begin
                        n_newest = r_in_idx;
                        n_line   = LINE_LP;
                        n_tap    = '0;
                        n_state  = S_RUN;
                    end
                end
            end
            S_RUN: begin
                n_mac_ctl.vld = 1'b1;
                n_mac_ctl.clr = (r_tap == '0);
                n_mac_ctl.cw  = r_line;
                n_mac_ctl.tap = r_tap;
                n_tap         = r_tap + 1'b1;
                if (r_tap == TAP_W'(TAP_COUNT - 1)) begin
                    n_drain = '0;
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_drain = r_drain + 1'b1;
                if (r_drain == DRAIN_LAST) begin
                    if (r_line == LINE_LP && r_cw_en) begin
                        // The low-pass value enters the CW line; the write
                        // lands before the first read of the second pass.
                        w_mem_req.we    = 1'b1;
                        w_mem_req.waddr = {LINE_CW, r_cw_idx};
                        w_mem_req.wdata = w_acc[Q_SHIFT +: SAMPLE_W];
                        n_newest        = r_cw_idx;
                        n_cw_idx        = r_cw_idx + 1'b1;
                        n_line          = LINE_CW;
                        n_tap           = '0;
                        n_state         = S_RUN;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_OUT: begin
                if (!r_out_valid || w_out_xfer) begin
                    n_out_valid = 1'b1;
                    n_out_data  = w_acc[Q_SHIFT +: OUT_W];
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= 1'b0;
            r_in_idx    <= '0;
            r_cw_idx    <= '0;
            r_newest    <= '0;
            r_tap       <= '0;
            r_line      <= LINE_LP;
            r_drain     <= '0;
            r_cw_en     <= 1'b0;
            r_mac_ctl   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_in_idx    <= n_in_idx;
            r_cw_idx    <= n_cw_idx;
            r_newest    <= n_newest;
            r_tap       <= n_tap;
            r_line      <= n_line;
            r_drain     <= n_drain;
            r_mac_ctl   <= n_mac_ctl;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_cw_en <= i_cfg_wdata;
            end
        end
        r_out_data <= n_out_data;
    end

`ifndef SYNTHESIS
    // A sample on the producing phase must start a filter pass.
    a_start_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && !r_phase) |=> (r_state == S_RUN))
        else $error("producing sample did not start a filter pass");

    // Each input transfer advances the low-pass write index by exactly one.
    a_in_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_in_idx == TAP_W'($past(r_in_idx) + 1'b1)))
        else $error("input write index did not advance by one");

    // The CW write index only moves when the low-pass pass hands over.
    a_cw_idx_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DRAIN) |=> $stable(r_cw_idx))
        else $error("CW write index changed outside the hand-over");

    // A non-producing sample never raises the output valid.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && r_phase) |=> !$rose(r_out_valid))
        else $error("result raised on a non-producing sample");
`endif

endmodule

// ===== src/dfcw_mem.sv =====
// ============================================================================
// dfcw_mem
// Sample memory holding both delay lines, one write and one registered read
// port. Entries never written since reset read as zero.
// ============================================================================
module dfcw_mem (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  dfcw_pkg::t_mem_req                   i_req,
    output logic signed [dfcw_pkg::SAMPLE_W-1:0] o_rdata
);
    import dfcw_pkg::*;

    logic signed [SAMPLE_W-1:0] r_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0]       r_valid;
    logic signed [SAMPLE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_valid[i_req.raddr] ? r_mem[i_req.raddr] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.we) begin
            r_valid[i_req.waddr] <= 1'b1;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/dfcw_mac.sv =====
// ============================================================================
// dfcw_mac
// Multiply-accumulate unit: registered product of sample and coefficient,
// followed by the accumulator.
// ============================================================================
module dfcw_mac (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic signed [dfcw_pkg::SAMPLE_W-1:0] i_data,
    input  dfcw_pkg::t_mac_ctl                   i_ctl,
    output logic signed [dfcw_pkg::ACC_W-1:0]    o_acc
);
    import dfcw_pkg::*;

    logic signed [COEF_W-1:0] w_coef;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_vld;
    logic                     r_prod_clr;
    logic signed [ACC_W-1:0]  r_acc;

    assign w_coef = i_ctl.cw ? CW_COEF[i_ctl.tap] : LP_COEF[i_ctl.tap];
    assign w_prod = PROD_W'(i_data) * PROD_W'(w_coef);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
            r_prod_clr <= 1'b0;
        end else begin
            r_prod_vld <= i_ctl.vld;
            r_prod_clr <= i_ctl.clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (r_prod_vld) begin
            r_acc <= r_prod_clr ? ACC_W'(r_prod) : r_acc + ACC_W'(r_prod);
        end
    end

    assign o_acc = r_acc;

endmodule
